[rtl/core/four_register_alu_executor_top_defines.svh]
// Assertion macros shared by the core
`ifndef FOUR_REGISTER_ALU_EXECUTOR_TOP_DEFINES_SVH
`define FOUR_REGISTER_ALU_EXECUTOR_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle
`define FRAE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the next cycle
`define FRAE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/frae_pkg.sv]
`default_nettype none

package frae_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned REG_NUM   = 4;
    localparam int unsigned REG_IDX_W = 2;
    localparam int unsigned OPC_W     = 4;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned S_DATA_W  = 72;
    localparam int unsigned M_DATA_W  = 128;
    localparam int unsigned Q_DEPTH   = 2;
    localparam int unsigned Q_PTR_W   = 1;
    localparam int unsigned Q_CNT_W   = 2;

    localparam logic [DATA_W-1:0] MAP_LOW_RST  = 32'h7654_3210;
    localparam logic [DATA_W-1:0] MAP_HIGH_RST = 32'hFEDC_BA98;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HIGH = 1'b1;

    typedef enum logic [OPC_W-1:0] {
        OP_ADDR = 4'd0,
        OP_ADDI = 4'd1,
        OP_MULR = 4'd2,
        OP_MULI = 4'd3,
        OP_BANR = 4'd4,
        OP_BANI = 4'd5,
        OP_BORR = 4'd6,
        OP_BORI = 4'd7,
        OP_SETR = 4'd8,
        OP_SETI = 4'd9,
        OP_GTIR = 4'd10,
        OP_GTRI = 4'd11,
        OP_GTRR = 4'd12,
        OP_EQIR = 4'd13,
        OP_EQRI = 4'd14,
        OP_EQRR = 4'd15
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [DATA_W-1:0]     a;
        logic [DATA_W-1:0]     b;
        logic [REG_IDX_W-1:0]  dest;
    } t_instr;

    typedef struct packed {
        logic                 full;
        logic                 empty;
        logic [Q_CNT_W-1:0]   count;
    } t_q_status;

endpackage

`default_nettype wire

[rtl/core/frae_front.sv]
`default_nettype none

module frae_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [frae_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [frae_pkg::DATA_W-1:0]       i_cfg_wdata,
    input  wire logic [frae_pkg::OPC_W-1:0]        i_raw_opcode,
    input  wire logic [frae_pkg::DATA_W-1:0]       i_operand_a,
    input  wire logic [frae_pkg::DATA_W-1:0]       i_operand_b,
    input  wire logic [frae_pkg::REG_IDX_W-1:0]    i_dest_reg,
    output frae_pkg::t_instr                       o_instr
);

    logic [frae_pkg::DATA_W-1:0] r_map_low;
    logic [frae_pkg::DATA_W-1:0] r_map_high;
    logic [frae_pkg::DATA_W-1:0] map_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_low  <= frae_pkg::MAP_LOW_RST;
            r_map_high <= frae_pkg::MAP_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                frae_pkg::CFG_MAP_LOW:  r_map_low  <= i_cfg_wdata;
                frae_pkg::CFG_MAP_HIGH: r_map_high <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // remap raw opcode through the table
    always_comb begin
        map_word      = i_raw_opcode[3] ? r_map_high : r_map_low;
        o_instr.op    = frae_pkg::t_op'(map_word[{i_raw_opcode[2:0], 2'b00} +: frae_pkg::OPC_W]);
        o_instr.a     = i_operand_a;
        o_instr.b     = i_operand_b;
        o_instr.dest  = i_dest_reg;
    end

endmodule

`default_nettype wire

[rtl/core/frae_queue.sv]
`default_nettype none

module frae_queue (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire frae_pkg::t_instr i_instr,
    input  wire logic         i_pop,
    output frae_pkg::t_instr  o_instr,
    output frae_pkg::t_q_status o_status
);

    frae_pkg::t_instr                r_mem [frae_pkg::Q_DEPTH];
    logic [frae_pkg::Q_PTR_W-1:0]    r_wr_ptr;
    logic [frae_pkg::Q_PTR_W-1:0]    r_rd_ptr;
    logic [frae_pkg::Q_CNT_W-1:0]    r_count;
    logic [frae_pkg::Q_CNT_W-1:0]    n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + frae_pkg::Q_CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - frae_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + frae_pkg::Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + frae_pkg::Q_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_instr;
        end
    end

    assign o_instr        = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == frae_pkg::Q_CNT_W'(frae_pkg::Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;

endmodule

`default_nettype wire

[rtl/core/frae_back.sv]
`default_nettype none

module frae_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_q_empty,
    input  wire frae_pkg::t_instr                i_instr,
    output logic                                 o_pop,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [frae_pkg::M_DATA_W-1:0]        o_m_tdata
);

    logic [frae_pkg::DATA_W-1:0] r_regs [frae_pkg::REG_NUM];
    logic [frae_pkg::DATA_W-1:0] ra;
    logic [frae_pkg::DATA_W-1:0] rb;
    logic [frae_pkg::DATA_W-1:0] mul_rhs;
    logic [frae_pkg::DATA_W-1:0] mul_res;
    logic [frae_pkg::DATA_W-1:0] n_result;
    logic                        r_valid;
    logic [frae_pkg::M_DATA_W-1:0] r_data;
    logic [frae_pkg::M_DATA_W-1:0] n_data;

    assign o_pop = !i_q_empty && (!r_valid || i_m_tready);

    always_comb begin
        ra       = r_regs[i_instr.a[frae_pkg::REG_IDX_W-1:0]];
        rb       = r_regs[i_instr.b[frae_pkg::REG_IDX_W-1:0]];
        mul_rhs  = (i_instr.op == frae_pkg::OP_MULI) ? i_instr.b : rb;
        mul_res  = ra * mul_rhs;
        n_result = '0;
        unique case (i_instr.op)
            frae_pkg::OP_ADDR: n_result = ra + rb;
            frae_pkg::OP_ADDI: n_result = ra + i_instr.b;
            frae_pkg::OP_MULR: n_result = mul_res;
            frae_pkg::OP_MULI: n_result = mul_res;
            frae_pkg::OP_BANR: n_result = ra & rb;
            frae_pkg::OP_BANI: n_result = ra & i_instr.b;
            frae_pkg::OP_BORR: n_result = ra | rb;
            frae_pkg::OP_BORI: n_result = ra | i_instr.b;
            frae_pkg::OP_SETR: n_result = ra;
            frae_pkg::OP_SETI: n_result = i_instr.a;
            frae_pkg::OP_GTIR: n_result = frae_pkg::DATA_W'($signed(i_instr.a) > $signed(rb));
            frae_pkg::OP_GTRI: n_result = frae_pkg::DATA_W'($signed(ra) > $signed(i_instr.b));
            frae_pkg::OP_GTRR: n_result = frae_pkg::DATA_W'($signed(ra) > $signed(rb));
            frae_pkg::OP_EQIR: n_result = frae_pkg::DATA_W'(i_instr.a == rb);
            frae_pkg::OP_EQRI: n_result = frae_pkg::DATA_W'(ra == i_instr.b);
            frae_pkg::OP_EQRR: n_result = frae_pkg::DATA_W'(ra == rb);
            default:           n_result = '0;
        endcase
    end

    // snapshot of the register file after the write
    always_comb begin
        for (int k = 0; k < frae_pkg::REG_NUM; k++) begin
            n_data[k*frae_pkg::DATA_W +: frae_pkg::DATA_W] =
                (i_instr.dest == frae_pkg::REG_IDX_W'(k)) ? n_result : r_regs[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < frae_pkg::REG_NUM; k++) begin
                r_regs[k] <= '0;
            end
        end else if (o_pop) begin
            r_regs[i_instr.dest] <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;

endmodule

`default_nettype wire

[rtl/core/four_register_alu_executor_top.sv]
// Four-register ALU executor.
// Slave stream: one instruction word per handshake on i_s_tdata.
// Master stream: one word per instruction with all four registers after it.
// Config port: i_cfg_we with i_cfg_index 0 writes the map for raw opcodes
//   0 to 7, index 1 the map for 8 to 15; write only while the core is idle.
// The front remaps the raw opcode and pushes into a two-entry queue; the
//   back reads the queue, runs the ALU and writes the register file and the
//   output register in the same cycle.
// An accepted word is written into the queue, then popped by the back end into the output register behind o_m_tvalid.
// Throughput: one word per cycle while i_m_tready is high, set by the combinational ALU and
//   register write of the back end.
// Reset: registers clear to zero, maps return to the identity table, the
//   queue and the output register empty.
// Stall: while i_m_tready is low the output word holds, the queue fills,
//   and o_s_tready drops once both queue entries are taken.
`default_nettype none

`include "four_register_alu_executor_top_defines.svh"

module four_register_alu_executor_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [frae_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [frae_pkg::DATA_W-1:0]       i_cfg_wdata,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // raw_opcode[3:0], operand_a[35:4], operand_b[67:36], dest_reg[69:68], zero[71:70]
    input  wire logic [frae_pkg::S_DATA_W-1:0]     i_s_tdata,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // reg_zero[31:0], reg_one[63:32], reg_two[95:64], reg_three[127:96]
    output logic [frae_pkg::M_DATA_W-1:0]          o_m_tdata
);

    frae_pkg::t_instr    front_instr;
    frae_pkg::t_instr    back_instr;
    frae_pkg::t_q_status q_status;
    logic                push;
    logic                pop;

    assign o_s_tready = !q_status.full;
    assign push       = i_s_tvalid && o_s_tready;

    frae_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_raw_opcode (i_s_tdata[3:0]),
        .i_operand_a  (i_s_tdata[35:4]),
        .i_operand_b  (i_s_tdata[67:36]),
        .i_dest_reg   (i_s_tdata[69:68]),
        .o_instr      (front_instr)
    );

    frae_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_instr  (front_instr),
        .i_pop    (pop),
        .o_instr  (back_instr),
        .o_status (q_status)
    );

    frae_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_status.empty),
        .i_instr    (back_instr),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    `FRAE_ASSERT_NEXT(a_pop_shows, i_clk, i_rst_n, pop, o_m_tvalid)
    `FRAE_ASSERT_NEXT(a_drain_clears, i_clk, i_rst_n, o_m_tvalid && i_m_tready && !pop, !o_m_tvalid)
    `FRAE_ASSERT_NEXT(a_q_fill, i_clk, i_rst_n, push && !pop, q_status.count == $past(q_status.count) + 2'd1)
    `FRAE_ASSERT_SAME(a_pop_nonempty, i_clk, i_rst_n, pop, q_status.count != 2'd0)

endmodule

`default_nettype wire
